@@ rtl/sbt_pkg.sv @@
// Sprite blitter package: screen size, register indexes, draw modes and the
// structs passed between the config block and the two pipeline stages.
// No dependencies.
package sbt_pkg;

   localparam int unsigned CoordWidth = 10;
   localparam logic [CoordWidth-1:0] SCREEN_WIDTH  = 10'd320;
   localparam logic [CoordWidth-1:0] SCREEN_HEIGHT = 10'd200;
   localparam int unsigned CsrDataWidth  = 9;
   localparam int unsigned CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_DRAW_MODE     = 3'd4,
      CSR_FG_COLOR      = 3'd5,
      CSR_BG_COLOR      = 3'd6,
      CSR_COLOR_BANK    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SOLID = 2'd0,
      MODE_KEYED = 2'd1,
      MODE_TWO   = 2'd2
   } draw_mode_type;

   typedef struct packed {
      logic [8:0]    origin_x;
      logic [8:0]    origin_y;
      logic [8:0]    sprite_width;
      logic [7:0]    sprite_height;
      draw_mode_type draw_mode;
      logic [7:0]    fg_color;
      logic [7:0]    bg_color;
      logic [3:0]    color_bank;
   } cfg_type;

   // beat held between the address stage and the shading stage
   typedef struct packed {
      logic [7:0]            pixel;
      logic [CoordWidth-1:0] px;
      logic [CoordWidth-1:0] py;
      logic                  last;
   } addr_beat_type;

endpackage

@@ rtl/sbt_csr.sv @@
// Sprite blitter configuration registers, written through a plain write port.
// Depends on sbt_pkg.
module sbt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sbt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [sbt_pkg::CsrDataWidth-1:0]    csr_wdata,
   output sbt_pkg::cfg_type                    cfg
);
   import sbt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:      cfg_in.origin_x      = csr_wdata;
            CSR_ORIGIN_Y:      cfg_in.origin_y      = csr_wdata;
            CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_wdata;
            CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_wdata[7:0];
            CSR_DRAW_MODE:     cfg_in.draw_mode     = draw_mode_type'(csr_wdata[1:0]);
            CSR_FG_COLOR:      cfg_in.fg_color      = csr_wdata[7:0];
            CSR_BG_COLOR:      cfg_in.bg_color      = csr_wdata[7:0];
            CSR_COLOR_BANK:    cfg_in.color_bank    = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: 9'd0, origin_y: 9'd0, sprite_width: 9'd1,
                     sprite_height: 8'd1, draw_mode: MODE_SOLID, fg_color: 8'd0,
                     bg_color: 8'd0, color_bank: 4'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/sbt_addr.sv @@
// Sprite blitter address stage: column/row counters, screen position and
// end-of-frame flag, registered into the stage-one beat. Depends on sbt_pkg.
module sbt_addr (
   input  logic                   clock,
   input  logic                   reset,
   input  sbt_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_pixel_value,
   output logic                   s1_valid,
   input  logic                   s1_ready,
   output sbt_pkg::addr_beat_type s1_beat
);
   import sbt_pkg::*;

   logic [8:0]    col_ff, col_in;
   logic [7:0]    row_ff, row_in;
   logic          valid_ff, valid_in;
   addr_beat_type beat_ff, beat_in;
   logic          req_fire;
   logic          col_end;
   logic          row_end;

   assign req_ready = !valid_ff || s1_ready;
   assign req_fire  = req_valid && req_ready;

   // a counter whose next value reaches or passes its limit is treated as the end of its row/frame
   assign col_end = ({1'b0, col_ff} + 10'd1) >= {1'b0, cfg.sprite_width};
   assign row_end = ({1'b0, row_ff} + 9'd1) >= {1'b0, cfg.sprite_height};

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      beat_in  = beat_ff;
      valid_in = valid_ff && !s1_ready;
      if (req_fire) begin
         valid_in      = 1'b1;
         beat_in.pixel = req_pixel_value;
         beat_in.px    = {1'b0, cfg.origin_x} + {1'b0, col_ff};
         beat_in.py    = {1'b0, cfg.origin_y} + {2'b00, row_ff};
         beat_in.last  = col_end && row_end;
         if (col_end) begin
            col_in = 9'd0;
            row_in = row_end ? 8'd0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 9'd0;
         row_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign s1_valid = valid_ff;
   assign s1_beat  = beat_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && col_end && row_end |=> col_ff == 9'd0 && row_ff == 8'd0)
      else $error("counters not cleared after last pixel");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !s1_ready |=> valid_ff && $stable(beat_ff))
      else $error("stage-one beat lost while stalled");

   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      req_fire && !col_end |=> row_ff == $past(row_ff))
      else $error("row advanced mid-row");

endmodule

@@ rtl/sbt_shade.sv @@
// Sprite blitter shading stage: draw mode, color key, bank offset and screen
// clipping into the result register. Depends on sbt_pkg.
module sbt_shade (
   input  logic                   clock,
   input  logic                   reset,
   input  sbt_pkg::cfg_type       cfg,
   input  logic                   s1_valid,
   output logic                   s1_ready,
   input  sbt_pkg::addr_beat_type s1_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_write_enable,
   output logic [9:0]             rsp_pixel_x,
   output logic [9:0]             rsp_pixel_y,
   output logic [7:0]             rsp_pixel_color,
   output logic                   rsp_last
);
   import sbt_pkg::*;

   logic       valid_ff, valid_in;
   logic       we_ff, we_in;
   logic [9:0] x_ff, x_in;
   logic [9:0] y_ff, y_in;
   logic [7:0] color_ff, color_in;
   logic       last_ff, last_in;
   logic       fire;
   logic       on_screen;
   logic       mode_we;
   logic [7:0] mode_color;

   assign s1_ready  = !valid_ff || rsp_ready;
   assign fire      = s1_valid && s1_ready;
   assign on_screen = (s1_beat.px < SCREEN_WIDTH) && (s1_beat.py < SCREEN_HEIGHT);

   always_comb begin
      mode_we    = 1'b0;
      mode_color = 8'd0;
      case (cfg.draw_mode)
         MODE_SOLID: begin
            mode_we    = 1'b1;
            mode_color = s1_beat.pixel;
         end
         MODE_KEYED: begin
            mode_we    = s1_beat.pixel != 8'd0;
            mode_color = s1_beat.pixel + {cfg.color_bank, 4'b0000};
         end
         MODE_TWO: begin
            mode_we    = (s1_beat.pixel != 8'd0) || (cfg.bg_color != 8'd0);
            mode_color = (s1_beat.pixel != 8'd0) ? cfg.fg_color : cfg.bg_color;
         end
         default: begin
            mode_we    = 1'b0;
            mode_color = 8'd0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      we_in    = we_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      color_in = color_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         we_in    = mode_we && on_screen;
         x_in     = s1_beat.px;
         y_in     = s1_beat.py;
         color_in = (mode_we && on_screen) ? mode_color : 8'd0;
         last_in  = s1_beat.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      we_ff    <= we_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_pixel_x      = x_ff;
   assign rsp_pixel_y      = y_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_last         = last_ff;

   a_clipped: assert property (@(posedge clock) disable iff (reset)
      valid_ff && we_ff |-> x_ff < SCREEN_WIDTH && y_ff < SCREEN_HEIGHT)
      else $error("write outside the screen");

   a_idle_color: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !we_ff |-> color_ff == 8'd0)
      else $error("unwritten pixel carries a color");

   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      fire |=> valid_ff && x_ff == $past(s1_beat.px) && last_ff == $past(s1_beat.last))
      else $error("result register missed a beat");

endmodule

@@ rtl/sprite_blit_transparent.sv @@
// Sprite blitter with color key, top level: config registers, address stage
// and shading stage. Depends on sbt_pkg, sbt_csr, sbt_addr, sbt_shade.
//
//   channel  ports                                       direction
//   req      req_valid/req_ready, req_pixel_value        in, one beat per pixel
//   rsp      rsp_valid/rsp_ready, rsp_write_enable,      out, one beat per pixel
//            rsp_pixel_x/y, rsp_pixel_color, rsp_last
//   csr      csr_write_enable, csr_index, csr_wdata      in, write only
//
// One pixel per clock sustained while rsp is ready; an accepted pixel passes through
// the address register, then the result register.
// Synchronous reset clears the counters and valid flags; config resets to 1x1 solid.
// A stalled rsp holds its beat; each stage still takes a beat in the cycle
// its successor drains, so a full pipeline never inserts a bubble.
module sprite_blit_transparent (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_write_enable,
   output logic [9:0]                        rsp_pixel_x,
   output logic [9:0]                        rsp_pixel_y,
   output logic [7:0]                        rsp_pixel_color,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [sbt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [sbt_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import sbt_pkg::*;

   cfg_type       cfg;
   logic          s1_valid;
   logic          s1_ready;
   addr_beat_type s1_beat;

   sbt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   sbt_addr u_addr (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .s1_valid        (s1_valid),
      .s1_ready        (s1_ready),
      .s1_beat         (s1_beat)
   );

   sbt_shade u_shade (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .s1_valid         (s1_valid),
      .s1_ready         (s1_ready),
      .s1_beat          (s1_beat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last         (rsp_last)
   );

endmodule

@@ verif/sprite_blit_transparent_tb.sv @@
// Self-checking bench for sprite_blit_transparent: directed table, then random
// frames under random stalls, each rsp beat checked against table or bench model.
// Depends on sbt_pkg and the sprite_blit_transparent RTL.
module sprite_blit_transparent_tb;
   import sbt_pkg::*;

   localparam logic [1:0]  MODE_UNUSED = 2'd3;
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned TailCycles  = 10;
   localparam int unsigned StallLimit  = 2000;
   localparam int unsigned RandomItems = 800;

   typedef struct packed {
      logic       we;
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] color;
      logic       last;
   } screen_write_type;

   typedef enum {ROW_CFG, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      csr_index_type    idx;
      logic [8:0]       data;
      logic [7:0]       pix;
      bit               fixed;
      screen_write_type want;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_pixel_value;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_write_enable;
   logic [9:0] rsp_pixel_x;
   logic [9:0] rsp_pixel_y;
   logic [7:0] rsp_pixel_color;
   logic       rsp_last;
   logic       csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   // blitter model state
   logic [8:0] org_x, org_y, spr_w;
   logic [7:0] spr_h;
   logic [1:0] mode;
   logic [7:0] fg, bg;
   logic [3:0] bank;
   logic [8:0] col_cnt;
   logic [7:0] row_cnt;

   screen_write_type pending_writes[$];
   stim_row_type     directed_rows[$];
   int unsigned      errors = 0;
   int unsigned      pixels_sent = 0;
   int unsigned      idle_cycles = 0;
   bit               steady = 1'b0;

   sprite_blit_transparent dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reset_blitter();
      org_x   = '0;
      org_y   = '0;
      spr_w   = 9'd1;
      spr_h   = 8'd1;
      mode    = MODE_SOLID;
      fg      = '0;
      bg      = '0;
      bank    = '0;
      col_cnt = '0;
      row_cnt = '0;
   endfunction

   function automatic void apply_reg(input csr_index_type idx, input logic [8:0] data);
      case (idx)
         CSR_ORIGIN_X:      org_x = data;
         CSR_ORIGIN_Y:      org_y = data;
         CSR_SPRITE_WIDTH:  spr_w = data;
         CSR_SPRITE_HEIGHT: spr_h = data[7:0];
         CSR_DRAW_MODE:     mode  = data[1:0];
         CSR_FG_COLOR:      fg    = data[7:0];
         CSR_BG_COLOR:      bg    = data[7:0];
         CSR_COLOR_BANK:    bank  = data[3:0];
         default: ;
      endcase
   endfunction

   function automatic screen_write_type blit_pixel(input logic [7:0] pix);
      screen_write_type w;
      logic             on_screen;
      logic             col_end;
      logic             row_end;
      w.x       = {1'b0, org_x} + {1'b0, col_cnt};
      w.y       = {1'b0, org_y} + {2'b00, row_cnt};
      on_screen = (w.x < SCREEN_WIDTH) && (w.y < SCREEN_HEIGHT);
      col_end   = (int'(col_cnt) + 1) >= int'(spr_w);
      row_end   = (int'(row_cnt) + 1) >= int'(spr_h);
      w.we      = 1'b0;
      w.color   = '0;
      case (mode)
         MODE_SOLID: begin
            w.we    = 1'b1;
            w.color = pix;
         end
         MODE_KEYED: begin
            if (pix != 8'd0) begin
               w.we    = 1'b1;
               w.color = pix + {bank, 4'h0};
            end
         end
         MODE_TWO: begin
            if (pix != 8'd0) begin
               w.we    = 1'b1;
               w.color = fg;
            end else if (bg != 8'd0) begin
               w.we    = 1'b1;
               w.color = bg;
            end
         end
         default: ;
      endcase
      if (!on_screen) w.we = 1'b0;
      if (!w.we) w.color = '0;
      w.last = col_end && row_end;
      if (col_end) begin
         col_cnt = '0;
         row_cnt = row_end ? 8'd0 : row_cnt + 8'd1;
      end else begin
         col_cnt = col_cnt + 9'd1;
      end
      return w;
   endfunction

   function automatic void cfg_row(input csr_index_type idx, input logic [8:0] data);
      stim_row_type r;
      r = '{ROW_CFG, idx, data, 8'd0, 1'b0, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void pix_row(input logic [7:0] pix);
      stim_row_type r;
      r = '{ROW_PIX, CSR_ORIGIN_X, 9'd0, pix, 1'b0, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void pix_fixed(input logic [7:0] pix, input logic we, input logic [9:0] x,
                                     input logic [9:0] y, input logic [7:0] color,
                                     input logic last);
      stim_row_type r;
      r = '{ROW_PIX, CSR_ORIGIN_X, 9'd0, pix, 1'b1, '{we, x, y, color, last}};
      directed_rows.push_back(r);
   endfunction

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic send_pixel(input logic [7:0] pix, input bit fixed,
                             input screen_write_type want);
      screen_write_type pred;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      pred = blit_pixel(pix);
      pending_writes.push_back(fixed ? want : pred);
      pixels_sent++;
   endtask

   // drop valid and wait until the pipeline is empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [8:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic pick_setting();
      int unsigned r;
      logic [8:0]  v;
      if ($urandom_range(0, 9) < 6) begin
         r = $urandom_range(0, 3);
         v = (r == 0) ? 9'd0 : (r == 1) ? 9'd511 :
             (r == 2) ? 9'($urandom_range(300, 330)) : 9'($urandom_range(0, 511));
         write_reg(CSR_ORIGIN_X, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         r = $urandom_range(0, 3);
         v = (r == 0) ? 9'd0 : (r == 1) ? 9'd511 :
             (r == 2) ? 9'($urandom_range(185, 205)) : 9'($urandom_range(0, 511));
         write_reg(CSR_ORIGIN_Y, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         r = $urandom_range(0, 19);
         case (r)
            0:       v = 9'd0;
            1:       v = 9'd320;
            2:       v = 9'd511;
            3:       v = 9'($urandom_range(321, 510));
            4, 5:    v = 9'($urandom_range(9, 40));
            default: v = 9'($urandom_range(1, 8));
         endcase
         write_reg(CSR_SPRITE_WIDTH, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         r = $urandom_range(0, 19);
         case (r)
            0:       v[7:0] = 8'd0;
            1:       v[7:0] = 8'd200;
            2:       v[7:0] = 8'd255;
            3:       v[7:0] = 8'($urandom_range(9, 30));
            default: v[7:0] = 8'($urandom_range(1, 6));
         endcase
         v[8] = 1'($urandom_range(0, 1));
         write_reg(CSR_SPRITE_HEIGHT, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         v = ($urandom_range(0, 7) == 0) ? 9'(MODE_UNUSED) : 9'($urandom_range(0, 2));
         write_reg(CSR_DRAW_MODE, v);
      end
      if ($urandom_range(0, 9) < 5) write_reg(CSR_FG_COLOR, 9'($urandom_range(0, 511)));
      if ($urandom_range(0, 9) < 5) begin
         v = ($urandom_range(0, 2) == 0) ? 9'd0 : 9'($urandom_range(0, 511));
         write_reg(CSR_BG_COLOR, v);
      end
      if ($urandom_range(0, 9) < 5) write_reg(CSR_COLOR_BANK, 9'($urandom_range(0, 511)));
   endtask

   // pixels in this phase: mostly the rest of the frame, sometimes one more frame
   function automatic int unsigned phase_length();
      int unsigned w, h, frame, cnt;
      w     = (spr_w == 0) ? 1 : spr_w;
      h     = (spr_h == 0) ? 1 : spr_h;
      frame = w * h;
      if ($urandom_range(0, 9) < 8) begin
         if (col_cnt < w && row_cnt < h) cnt = frame - (row_cnt * w + col_cnt);
         else cnt = $urandom_range(1, 8);
         if (frame <= 32 && $urandom_range(0, 1) == 1) cnt += frame;
         if (cnt > 64 && !($urandom_range(0, 7) == 0 && cnt <= 520))
            cnt = $urandom_range(1, 64);
      end else begin
         cnt = $urandom_range(1, 12);
      end
      return cnt;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      screen_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            report("rsp beat with no write expected");
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_enable !== want.we)
               report($sformatf("write_enable %b, want %b", rsp_write_enable, want.we));
            if (rsp_pixel_x !== want.x)
               report($sformatf("pixel_x %0d, want %0d", rsp_pixel_x, want.x));
            if (rsp_pixel_y !== want.y)
               report($sformatf("pixel_y %0d, want %0d", rsp_pixel_y, want.y));
            if (rsp_pixel_color !== want.color)
               report($sformatf("pixel_color %h, want %h", rsp_pixel_color, want.color));
            if (rsp_last !== want.last)
               report($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
         $display("sprite_blit_transparent: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned      base;
      int unsigned      cnt;
      bit               prev_cfg;
      screen_write_type none;
      none             = '0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_value  = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      reset_blitter();

      // after reset: 1x1 solid at the origin
      pix_fixed(8'hFF, 1'b1, 10'd0, 10'd0, 8'hFF, 1'b1);
      pix_fixed(8'h00, 1'b1, 10'd0, 10'd0, 8'h00, 1'b1);
      // right and bottom screen edge
      cfg_row(CSR_ORIGIN_X, 9'd319);
      cfg_row(CSR_ORIGIN_Y, 9'd199);
      cfg_row(CSR_SPRITE_WIDTH, 9'd2);
      pix_fixed(8'h5A, 1'b1, 10'd319, 10'd199, 8'h5A, 1'b0);
      pix_fixed(8'h01, 1'b0, 10'd320, 10'd199, 8'h00, 1'b1);
      // keyed, top bank wraps
      cfg_row(CSR_DRAW_MODE, 9'(MODE_KEYED));
      cfg_row(CSR_COLOR_BANK, 9'd15);
      cfg_row(CSR_ORIGIN_X, 9'd0);
      cfg_row(CSR_ORIGIN_Y, 9'd0);
      cfg_row(CSR_SPRITE_WIDTH, 9'd1);
      pix_fixed(8'h00, 1'b0, 10'd0, 10'd0, 8'h00, 1'b1);
      pix_fixed(8'h20, 1'b1, 10'd0, 10'd0, 8'h10, 1'b1);
      pix_fixed(8'hFF, 1'b1, 10'd0, 10'd0, 8'hEF, 1'b1);
      // two-color, background off then on
      cfg_row(CSR_DRAW_MODE, 9'(MODE_TWO));
      cfg_row(CSR_FG_COLOR, 9'hAA);
      cfg_row(CSR_BG_COLOR, 9'h00);
      pix_fixed(8'h00, 1'b0, 10'd0, 10'd0, 8'h00, 1'b1);
      pix_fixed(8'h07, 1'b1, 10'd0, 10'd0, 8'hAA, 1'b1);
      cfg_row(CSR_BG_COLOR, 9'h55);
      pix_fixed(8'h00, 1'b1, 10'd0, 10'd0, 8'h55, 1'b1);
      // background write below the screen is clipped
      cfg_row(CSR_ORIGIN_Y, 9'd200);
      pix_fixed(8'h00, 1'b0, 10'd0, 10'd200, 8'h00, 1'b1);
      // unused mode writes nothing
      cfg_row(CSR_DRAW_MODE, 9'(MODE_UNUSED));
      cfg_row(CSR_ORIGIN_Y, 9'd0);
      pix_fixed(8'hFF, 1'b0, 10'd0, 10'd0, 8'h00, 1'b1);
      // zero size acts as 1x1, max origin
      cfg_row(CSR_DRAW_MODE, 9'(MODE_SOLID));
      cfg_row(CSR_SPRITE_WIDTH, 9'd0);
      cfg_row(CSR_SPRITE_HEIGHT, 9'd0);
      cfg_row(CSR_ORIGIN_X, 9'd511);
      cfg_row(CSR_ORIGIN_Y, 9'd511);
      pix_fixed(8'h33, 1'b0, 10'd511, 10'd511, 8'h00, 1'b1);
      // shrink the size under running counters
      cfg_row(CSR_ORIGIN_X, 9'd0);
      cfg_row(CSR_ORIGIN_Y, 9'd0);
      cfg_row(CSR_SPRITE_WIDTH, 9'd4);
      cfg_row(CSR_SPRITE_HEIGHT, 9'd3);
      pix_row(8'h11);
      pix_row(8'h22);
      pix_row(8'h33);
      cfg_row(CSR_SPRITE_WIDTH, 9'd2);
      pix_row(8'h44);
      cfg_row(CSR_SPRITE_HEIGHT, 9'd1);
      pix_row(8'h55);
      pix_row(8'h66);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      prev_cfg = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            if (!prev_cfg) settle();
            write_reg(directed_rows[i].idx, directed_rows[i].data);
            prev_cfg = 1'b1;
         end else begin
            send_pixel(directed_rows[i].pix, directed_rows[i].fixed, directed_rows[i].want);
            prev_cfg = 1'b0;
         end
      end

      base = pixels_sent;
      while (pixels_sent < base + RandomItems) begin
         settle();
         pick_setting();
         steady = (pixels_sent - base >= 300) && (pixels_sent - base < 450);
         cnt    = phase_length();
         repeat (cnt) begin
            case ($urandom_range(0, 7))
               0, 1:    send_pixel(8'h00, 1'b0, none);
               2:       send_pixel(8'hFF, 1'b0, none);
               default: send_pixel(8'($urandom_range(0, 255)), 1'b0, none);
            endcase
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (errors == 0) begin
         $display("sprite_blit_transparent: match");
      end else begin
         $display("sprite_blit_transparent: mismatch");
      end
      $finish;
   end

endmodule
